// File: design/wsv_pkg.sv
// ----------------------------------------------------------------------------
// wsv_pkg: shared types and constants of the weighted semivariogram unit
// Shared-unit operation codes, request/response words and memory word layouts.
// ----------------------------------------------------------------------------
package wsv_pkg;

  // dividend width of the shared divider: a 64-bit sum shifted left by 15
  localparam int DVD_W = 79;

  typedef enum logic [2:0] {
    ALU_MUL  = 3'b001,
    ALU_DIV  = 3'b010,
    ALU_SQRT = 3'b100
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] w;
    logic [31:0] z;
  } pt_t;

  typedef struct packed {
    logic [63:0] wsum;
    logic [63:0] dsum;
  } bin_t;

endpackage

// File: design/wsv_if.sv
// ----------------------------------------------------------------------------
// wsv_if: handshake channels of the weighted semivariogram unit
// Point input, bin result output and bin count configuration channels.
// ----------------------------------------------------------------------------
interface wsv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic        [31:0] offset_weight;
  logic        [31:0] observed_value;
  logic               last_point;

  modport source (output valid, coord_x, coord_y, offset_weight, observed_value,
                  last_point, input ready);
  modport sink   (input valid, coord_x, coord_y, offset_weight, observed_value,
                  last_point, output ready);
endinterface

interface wsv_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bin_index;
  logic [31:0] bin_center;
  logic [47:0] semivariance;
  logic        empty_bin;
  logic        last_bin;

  modport source (output valid, bin_index, bin_center, semivariance, empty_bin,
                  last_bin, input ready);
  modport sink   (input valid, bin_index, bin_center, semivariance, empty_bin,
                  last_bin, output ready);
endinterface

interface wsv_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

// File: design/weighted_semivariogram_unit.sv
// ----------------------------------------------------------------------------
// weighted_semivariogram_unit: weighted empirical binned semivariogram
// Stores points with their rates, then bins every pair by distance and
// reports one weighted semivariance per bin.
// ----------------------------------------------------------------------------
//  channel    dir  word                                             handshake
//  point_i    in   coord_x, coord_y, offset_weight, observed_value,  valid/ready
//                  last_point
//  result_o   out  bin_index, bin_center, semivariance, empty_bin,   valid/ready
//                  last_bin
//  cfg_i      in   bin_count                                        valid/ready
//
//  A zero-weight point is stored with a saturated rate; any other first takes a rate division.
//  On the last point, every pair j < i is visited twice, once for the extent
//  search and once for binning (which skips the bin multiply and division at
//  zero extent); the cost is set by the 32-step root and 79-step divider of the
//  one shared unit. Each bin is then worked out on that unit and held until taken.
//  Input is held off meanwhile.
//  Reset clears control state only; the point and bin memories need no clear.
// ----------------------------------------------------------------------------
module weighted_semivariogram_unit import wsv_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_BINS   = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  wsv_in_if.sink     point_i,
  wsv_out_if.source  result_o,
  wsv_cfg_if.sink    cfg_i
);

  localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int BAW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NBW = $clog2(MAX_BINS + 1);

  typedef enum logic [24:0] {
    S_IDLE   = 25'h0000001,
    S_RATE   = 25'h0000002,
    S_STORE  = 25'h0000004,
    S_INIT   = 25'h0000008,
    S_RDI    = 25'h0000010,
    S_LDI    = 25'h0000020,
    S_RDJ    = 25'h0000040,
    S_LDJ    = 25'h0000080,
    S_SQX    = 25'h0000100,
    S_SQY    = 25'h0000200,
    S_NEXT   = 25'h0000400,
    S_DMAX   = 25'h0000800,
    S_DST    = 25'h0001000,
    S_BMUL   = 25'h0002000,
    S_BDIV   = 25'h0004000,
    S_PW     = 25'h0008000,
    S_PQ     = 25'h0010000,
    S_PPS    = 25'h0020000,
    S_PP     = 25'h0040000,
    S_BWR    = 25'h0080000,
    S_OSTART = 25'h0100000,
    S_OMUL   = 25'h0200000,
    S_ODIV   = 25'h0400000,
    S_OSEMI  = 25'h0800000,
    S_OUT    = 25'h1000000
  } state_e;

  function automatic logic [31:0] sabs(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    logic        [32:0] n;
    d = $signed({a[31], a}) - $signed({b[31], b});
    n = -d;
    sabs = d[32] ? n[31:0] : d[31:0];
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[64] ? '1 : s[63:0];
  endfunction

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [NBW-1:0] k_q, k_d;
  logic [NBW-1:0] nb_q, nb_d;
  logic [6:0]    bc_q;
  logic          phase2_q, phase2_d;
  logic [63:0]   max_q, max_d;
  logic [MAX_BINS-1:0] bvalid_q, bvalid_d;
  logic [1:0]    m_q, m_d;

  // payload
  logic          last_q, last_d;
  logic [31:0]   xi_q, xi_d, yi_q, yi_d, wi_q, wi_d, zi_q, zi_d;
  logic [31:0]   dy_q, dy_d, dz_q, dz_d, wj_q, wj_d;
  logic [63:0]   sqx_q, sqx_d;
  logic [31:0]   dmax_q, dmax_d;
  logic [BAW-1:0] b_q, b_d;
  logic [47:0]   p_q, p_d, q_q, q_d;
  logic [95:0]   acc_q, acc_d;
  logic [31:0]   center_q, center_d;
  logic [47:0]   semi_q, semi_d;
  logic          empty_q, empty_d;
  logic          lastb_q, lastb_d;

  // shared unit and memories
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [DVD_W-1:0] opa;
  logic [63:0]      opb;

  logic           pt_we;
  logic [PAW-1:0] pt_raddr;
  pt_t            pt_wr, pt_rd;
  logic           bin_we;
  logic [BAW-1:0] bin_raddr;
  bin_t           bin_wr, bin_rd, bin_cur;

  logic [8:0]  nb_raw;
  logic [63:0] s_sum;
  logic [63:0] diff;
  logic [95:0] pp_term;
  logic [31:0] pp_a, pp_b;

  assign pt_raddr  = (state_q == S_RDI) ? i_q[PAW-1:0] : j_q[PAW-1:0];
  assign bin_raddr = phase2_q ? b_q : k_q[BAW-1:0];
  assign pt_wr     = '{x: xi_q, y: yi_q, w: wi_q, z: zi_q};
  assign pt_we     = (state_q == S_STORE);
  assign bin_we    = (state_q == S_BWR);

  wsv_ram #(.WIDTH($bits(pt_t)), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (cnt_q[PAW-1:0]),
    .wdata_i (pt_wr),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rd)
  );

  wsv_ram #(.WIDTH($bits(bin_t)), .DEPTH(MAX_BINS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (b_q),
    .wdata_i (bin_wr),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rd)
  );

  wsv_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (opa),
    .opb_i  (opb),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    nb_d     = nb_q;
    phase2_d = phase2_q;
    max_d    = max_q;
    bvalid_d = bvalid_q;
    m_d      = m_q;
    last_d   = last_q;
    xi_d     = xi_q;
    yi_d     = yi_q;
    wi_d     = wi_q;
    zi_d     = zi_q;
    dy_d     = dy_q;
    dz_d     = dz_q;
    wj_d     = wj_q;
    sqx_d    = sqx_q;
    dmax_d   = dmax_q;
    b_d      = b_q;
    p_d      = p_q;
    q_d      = q_q;
    acc_d    = acc_q;
    center_d = center_q;
    semi_d   = semi_q;
    empty_d  = empty_q;
    lastb_d  = lastb_q;
    alu_req  = '{start: 1'b0, op: ALU_MUL};
    opa      = '0;
    opb      = '0;

    nb_raw = (bc_q == 7'd0) ? 9'd1 : {2'b00, bc_q};
    if (nb_raw > 9'(MAX_BINS)) begin
      nb_raw = 9'(MAX_BINS);
    end

    s_sum = sat_add(sqx_q, alu_rsp.res[63:0]);
    diff  = (acc_q[95:80] != 16'd0) ? '1 : acc_q[79:16];

    bin_cur = bvalid_q[bin_raddr] ? bin_rd : '0;
    bin_wr  = '{wsum: sat_add(bin_cur.wsum, {16'd0, p_q}),
                dsum: sat_add(bin_cur.dsum, diff)};

    case (m_q)
      2'd0:    begin pp_a = p_q[31:0];          pp_b = q_q[31:0]; end
      2'd1:    begin pp_a = p_q[31:0];          pp_b = {16'd0, q_q[47:32]}; end
      2'd2:    begin pp_a = {16'd0, p_q[47:32]}; pp_b = q_q[31:0]; end
      default: begin pp_a = {16'd0, p_q[47:32]}; pp_b = {16'd0, q_q[47:32]}; end
    endcase
    case (m_q)
      2'd0:    pp_term = 96'(alu_rsp.res[63:0]);
      2'd3:    pp_term = 96'(alu_rsp.res[63:0]) << 64;
      default: pp_term = 96'(alu_rsp.res[63:0]) << 32;
    endcase

    case (state_q)
      S_IDLE: begin
        if (point_i.valid) begin
          xi_d   = point_i.coord_x;
          yi_d   = point_i.coord_y;
          wi_d   = point_i.offset_weight;
          last_d = point_i.last_point;
          if (cnt_q < CW'(MAX_POINTS)) begin
            if (point_i.offset_weight == 32'd0) begin
              zi_d    = '1;
              state_d = S_STORE;
            end else begin
              alu_req = '{start: 1'b1, op: ALU_DIV};
              opa     = DVD_W'({point_i.observed_value, 16'd0});
              opb     = 64'(point_i.offset_weight);
              state_d = S_RATE;
            end
          end else if (point_i.last_point) begin
            state_d = S_INIT;
          end
        end
      end
      S_RATE: begin
        if (alu_rsp.done) begin
          zi_d    = (alu_rsp.res[DVD_W-1:32] != '0) ? '1 : alu_rsp.res[31:0];
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cnt_d   = cnt_q + CW'(1);
        state_d = last_q ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        nb_d     = NBW'(nb_raw);
        bvalid_d = '0;
        max_d    = '0;
        phase2_d = 1'b0;
        i_d      = CW'(1);
        j_d      = '0;
        k_d      = '0;
        if (cnt_q < CW'(2)) begin
          dmax_d  = '0;
          state_d = S_OSTART;
        end else begin
          state_d = S_RDI;
        end
      end
      S_RDI: state_d = S_LDI;
      S_LDI: begin
        xi_d    = pt_rd.x;
        yi_d    = pt_rd.y;
        wi_d    = pt_rd.w;
        zi_d    = pt_rd.z;
        j_d     = '0;
        state_d = S_RDJ;
      end
      S_RDJ: state_d = S_LDJ;
      S_LDJ: begin
        dy_d    = sabs(yi_q, pt_rd.y);
        dz_d    = (zi_q > pt_rd.z) ? zi_q - pt_rd.z : pt_rd.z - zi_q;
        wj_d    = pt_rd.w;
        alu_req = '{start: 1'b1, op: ALU_MUL};
        opa     = DVD_W'(sabs(xi_q, pt_rd.x));
        opb     = 64'(sabs(xi_q, pt_rd.x));
        state_d = S_SQX;
      end
      S_SQX: begin
        if (alu_rsp.done) begin
          sqx_d   = alu_rsp.res[63:0];
          alu_req = '{start: 1'b1, op: ALU_MUL};
          opa     = DVD_W'(dy_q);
          opb     = 64'(dy_q);
          state_d = S_SQY;
        end
      end
      S_SQY: begin
        if (alu_rsp.done) begin
          if (!phase2_q) begin
            if (s_sum > max_q) begin
              max_d = s_sum;
            end
            state_d = S_NEXT;
          end else begin
            alu_req = '{start: 1'b1, op: ALU_SQRT};
            opa     = DVD_W'(s_sum);
            state_d = S_DST;
          end
        end
      end
      S_NEXT: begin
        if (j_q + CW'(1) < i_q) begin
          j_d     = j_q + CW'(1);
          state_d = S_RDJ;
        end else if (i_q + CW'(1) < cnt_q) begin
          i_d     = i_q + CW'(1);
          state_d = S_RDI;
        end else if (!phase2_q) begin
          alu_req = '{start: 1'b1, op: ALU_SQRT};
          opa     = DVD_W'(max_q);
          state_d = S_DMAX;
        end else begin
          phase2_d = 1'b0;
          k_d      = '0;
          state_d  = S_OSTART;
        end
      end
      S_DMAX: begin
        if (alu_rsp.done) begin
          dmax_d   = alu_rsp.res[31:0];
          phase2_d = 1'b1;
          i_d      = CW'(1);
          state_d  = S_RDI;
        end
      end
      S_DST: begin
        if (alu_rsp.done) begin
          if (dmax_q == 32'd0) begin
            b_d     = '0;
            alu_req = '{start: 1'b1, op: ALU_MUL};
            opa     = DVD_W'(wi_q);
            opb     = 64'(wj_q);
            state_d = S_PW;
          end else begin
            alu_req = '{start: 1'b1, op: ALU_MUL};
            opa     = DVD_W'(alu_rsp.res[31:0]);
            opb     = 64'(nb_q);
            state_d = S_BMUL;
          end
        end
      end
      S_BMUL: begin
        if (alu_rsp.done) begin
          alu_req = '{start: 1'b1, op: ALU_DIV};
          opa     = alu_rsp.res;
          opb     = 64'(dmax_q);
          state_d = S_BDIV;
        end
      end
      S_BDIV: begin
        if (alu_rsp.done) begin
          // the farthest pair lands on the bin count: fold it into the last bin
          if (alu_rsp.res >= DVD_W'(nb_q)) begin
            b_d = BAW'(nb_q - NBW'(1));
          end else begin
            b_d = BAW'(alu_rsp.res);
          end
          alu_req = '{start: 1'b1, op: ALU_MUL};
          opa     = DVD_W'(wi_q);
          opb     = 64'(wj_q);
          state_d = S_PW;
        end
      end
      S_PW: begin
        if (alu_rsp.done) begin
          p_d     = alu_rsp.res[63:16];
          alu_req = '{start: 1'b1, op: ALU_MUL};
          opa     = DVD_W'(dz_q);
          opb     = 64'(dz_q);
          state_d = S_PQ;
        end
      end
      S_PQ: begin
        if (alu_rsp.done) begin
          q_d     = alu_rsp.res[63:16];
          m_d     = 2'd0;
          acc_d   = '0;
          state_d = S_PPS;
        end
      end
      S_PPS: begin
        alu_req = '{start: 1'b1, op: ALU_MUL};
        opa     = DVD_W'(pp_a);
        opb     = 64'(pp_b);
        state_d = S_PP;
      end
      S_PP: begin
        if (alu_rsp.done) begin
          acc_d = acc_q + pp_term;
          if (m_q == 2'd3) begin
            state_d = S_BWR;
          end else begin
            m_d     = m_q + 2'd1;
            state_d = S_PPS;
          end
        end
      end
      S_BWR: begin
        bvalid_d[b_q] = 1'b1;
        state_d       = S_NEXT;
      end
      S_OSTART: begin
        alu_req = '{start: 1'b1, op: ALU_MUL};
        opa     = DVD_W'({k_q, 1'b1});
        opb     = 64'(dmax_q);
        state_d = S_OMUL;
      end
      S_OMUL: begin
        if (alu_rsp.done) begin
          alu_req = '{start: 1'b1, op: ALU_DIV};
          opa     = alu_rsp.res;
          opb     = 64'({nb_q, 1'b0});
          state_d = S_ODIV;
        end
      end
      S_ODIV: begin
        if (alu_rsp.done) begin
          center_d = alu_rsp.res[31:0];
          lastb_d  = (k_q + NBW'(1) == nb_q);
          empty_d  = (bin_cur.wsum == 64'd0);
          if (bin_cur.wsum == 64'd0) begin
            semi_d  = '0;
            state_d = S_OUT;
          end else if ({33'd0, bin_cur.dsum} >= {bin_cur.wsum, 33'd0}) begin
            semi_d  = '1;
            state_d = S_OUT;
          end else begin
            alu_req = '{start: 1'b1, op: ALU_DIV};
            opa     = {bin_cur.dsum, 15'd0};
            opb     = bin_cur.wsum;
            state_d = S_OSEMI;
          end
        end
      end
      S_OSEMI: begin
        if (alu_rsp.done) begin
          semi_d  = alu_rsp.res[47:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (result_o.ready) begin
          if (lastb_q) begin
            cnt_d   = '0;
            max_d   = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + NBW'(1);
            state_d = S_OSTART;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      nb_q     <= NBW'(1);
      bc_q     <= 7'd16;
      phase2_q <= 1'b0;
      max_q    <= '0;
      bvalid_q <= '0;
      m_q      <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      nb_q     <= nb_d;
      phase2_q <= phase2_d;
      max_q    <= max_d;
      bvalid_q <= bvalid_d;
      m_q      <= m_d;
      if (cfg_i.valid) begin
        bc_q <= cfg_i.bin_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    xi_q     <= xi_d;
    yi_q     <= yi_d;
    wi_q     <= wi_d;
    zi_q     <= zi_d;
    dy_q     <= dy_d;
    dz_q     <= dz_d;
    wj_q     <= wj_d;
    sqx_q    <= sqx_d;
    dmax_q   <= dmax_d;
    b_q      <= b_d;
    p_q      <= p_d;
    q_q      <= q_d;
    acc_q    <= acc_d;
    center_q <= center_d;
    semi_q   <= semi_d;
    empty_q  <= empty_d;
    lastb_q  <= lastb_d;
  end

  assign point_i.ready         = (state_q == S_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = (state_q == S_OUT);
  assign result_o.bin_index    = 6'(k_q);
  assign result_o.bin_center   = center_q;
  assign result_o.semivariance = semi_q;
  assign result_o.empty_bin    = empty_q;
  assign result_o.last_bin     = lastb_q;

endmodule

// File: design/wsv_ram.sv
// ----------------------------------------------------------------------------
// wsv_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module wsv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/wsv_alu.sv
// ----------------------------------------------------------------------------
// wsv_alu: shared arithmetic unit
// Registered 32x32 multiply, one-bit-a-cycle long division, two-bit-a-cycle
// integer square root. Result held until the next start.
// ----------------------------------------------------------------------------
module wsv_alu import wsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alu_req_t         req_i,
  input  logic [DVD_W-1:0] opa_i,
  input  logic [63:0]      opb_i,
  output alu_rsp_t         rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  alu_op_e          op_q, op_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [DVD_W-1:0] res_q, res_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [64:0]      rem_q, rem_d;
  logic [63:0]      dvsr_q, dvsr_d;

  logic [63:0] prod;
  logic [64:0] rsh;
  logic [63:0] root_t;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    prod   = opa_i[31:0] * opb_i[31:0];
    rsh    = {rem_q[63:0], dvd_q[DVD_W-1]};
    root_t = res_q[63:0] + dvsr_q;

    if (req_i.start) begin
      op_d = req_i.op;
      case (req_i.op)
        ALU_MUL: begin
          res_d  = DVD_W'(prod);
          done_d = 1'b1;
        end
        ALU_DIV: begin
          busy_d = 1'b1;
          cnt_d  = 7'(DVD_W - 1);
          rem_d  = '0;
          dvd_d  = opa_i;
          dvsr_d = opb_i;
          res_d  = '0;
        end
        ALU_SQRT: begin
          busy_d = 1'b1;
          cnt_d  = 7'd31;
          rem_d  = {1'b0, opa_i[63:0]};
          res_d  = '0;
          dvsr_d = 64'h4000_0000_0000_0000;
        end
        default: ;
      endcase
    end else if (busy_q) begin
      if (op_q == ALU_DIV) begin
        // shift in one dividend bit, subtract when it fits
        if (rsh >= {1'b0, dvsr_q}) begin
          rem_d = rsh - {1'b0, dvsr_q};
          res_d = {res_q[DVD_W-2:0], 1'b1};
        end else begin
          rem_d = rsh;
          res_d = {res_q[DVD_W-2:0], 1'b0};
        end
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end else begin
        if (rem_q[63:0] >= root_t) begin
          rem_d = {1'b0, rem_q[63:0] - root_t};
          res_d = DVD_W'((res_q[63:0] >> 1) + dvsr_q);
        end else begin
          res_d = DVD_W'(res_q[63:0] >> 1);
        end
        dvsr_d = dvsr_q >> 2;
      end
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign rsp_o = '{done: done_q, res: res_q};

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the weighted semivariogram unit
// Drives point sets through the point channel and predicts every bin word
// in fixed point. Each result word is checked field by field as it leaves.
// The run covers directed corner sets, bin count extremes and random sets
// under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import wsv_pkg::*;

  localparam int NPTS  = 1024;
  localparam int NBINS = 64;
  localparam logic [47:0] SEMI_SAT = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] w;
    logic        [31:0] v;
    logic               last;
  } point_t;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] centre;
    logic [47:0] semi;
    logic        empty;
    logic        lastb;
  } bin_word_t;

  logic clk;
  logic rst_n;

  wsv_in_if  pt_if();
  wsv_out_if res_if();
  wsv_cfg_if cfg_if();

  weighted_semivariogram_unit u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .point_i (pt_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // predictor state
  logic [31:0] st_x [NPTS];
  logic [31:0] st_y [NPTS];
  logic [31:0] st_w [NPTS];
  logic [31:0] st_z [NPTS];
  int          st_count;
  logic [6:0]  bins_reg;
  bin_word_t   bins_due[$];

  int gap_pct;
  int stall_pct;
  int errors;
  int n_points;
  int n_sets;
  int n_bins;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] sq_dist(int i, int j);
    longint d;
    logic [63:0] dx;
    logic [63:0] dy;
    d  = longint'($signed(st_x[i])) - longint'($signed(st_x[j]));
    dx = d < 0 ? -d : d;
    d  = longint'($signed(st_y[i])) - longint'($signed(st_y[j]));
    dy = d < 0 ? -d : d;
    return add_sat(dx * dx, dy * dy);
  endfunction

  // store the point; on the last one work out every bin word of the set
  task automatic predict_set(point_t p);
    logic [47:0]  num;
    logic [47:0]  z;
    logic [63:0]  wsum [NBINS];
    logic [63:0]  dsum [NBINS];
    logic [63:0]  maxsq;
    logic [63:0]  dmax;
    logic [63:0]  d;
    logic [63:0]  b;
    logic [63:0]  pw;
    logic [63:0]  dz;
    logic [63:0]  q;
    logic [127:0] prod;
    logic [127:0] quo;
    int           nb;
    bin_word_t    bw;
    if (st_count < NPTS) begin
      z = 48'hFFFF_FFFF;
      if (p.w != 0) begin
        num = {p.v, 16'h0};
        z = num / p.w;
        if (z > 48'hFFFF_FFFF) z = 48'hFFFF_FFFF;
      end
      st_x[st_count] = p.x;
      st_y[st_count] = p.y;
      st_w[st_count] = p.w;
      st_z[st_count] = z[31:0];
      st_count++;
    end
    if (!p.last) return;
    nb = bins_reg == 0 ? 1 : int'(bins_reg);
    if (nb > NBINS) nb = NBINS;
    for (int k = 0; k < NBINS; k++) begin
      wsum[k] = '0;
      dsum[k] = '0;
    end
    maxsq = '0;
    for (int i = 1; i < st_count; i++)
      for (int j = 0; j < i; j++)
        if (sq_dist(i, j) > maxsq) maxsq = sq_dist(i, j);
    dmax = root64(maxsq);
    for (int i = 1; i < st_count; i++)
      for (int j = 0; j < i; j++) begin
        d  = root64(sq_dist(i, j));
        b  = dmax == 0 ? 0 : (d * nb) / dmax;
        if (b >= nb) b = nb - 1;  // farthest pair lands on the last bin
        pw = (64'(st_w[i]) * 64'(st_w[j])) >> 16;
        dz = st_z[i] > st_z[j] ? 64'(st_z[i] - st_z[j]) : 64'(st_z[j] - st_z[i]);
        q  = (dz * dz) >> 16;
        prod = (128'(pw) * 128'(q)) >> 16;
        wsum[b] = add_sat(wsum[b], pw);
        dsum[b] = add_sat(dsum[b], prod[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0]);
      end
    for (int k = 0; k < nb; k++) begin
      bw.idx    = k[5:0];
      d         = (64'(2 * k + 1) * dmax) / (64'(2 * nb));
      bw.centre = d[31:0];
      bw.empty  = wsum[k] == 0;
      bw.semi   = '0;
      if (!bw.empty) begin
        quo = (128'(dsum[k]) << 15) / 128'(wsum[k]);
        bw.semi = quo > 128'(SEMI_SAT) ? SEMI_SAT : quo[47:0];
      end
      bw.lastb = (k + 1 == nb);
      bins_due.push_back(bw);
    end
    st_count = 0;
    n_sets++;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    bin_word_t e;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (bins_due.size() == 0) begin
        report("unexpected bin word, index", res_if.bin_index, '0);
      end else begin
        e = bins_due.pop_front();
        n_bins++;
        if (res_if.bin_index !== e.idx) report("bin_index", res_if.bin_index, e.idx);
        if (res_if.bin_center !== e.centre) report("bin_center", res_if.bin_center, e.centre);
        if (res_if.semivariance !== e.semi) report("semivariance", res_if.semivariance, e.semi);
        if (res_if.empty_bin !== e.empty) report("empty_bin", res_if.empty_bin, e.empty);
        if (res_if.last_bin !== e.lastb) report("last_bin", res_if.last_bin, e.lastb);
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_point(point_t p);
    while ($urandom_range(99) < gap_pct) begin
      pt_if.valid = 1'b0;
      @(negedge clk);
    end
    pt_if.coord_x        = p.x;
    pt_if.coord_y        = p.y;
    pt_if.offset_weight  = p.w;
    pt_if.observed_value = p.v;
    pt_if.last_point     = p.last;
    pt_if.valid          = 1'b1;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    predict_set(p);
    n_points++;
    @(negedge clk);
  endtask

  // hold until every bin word is out, then let the block settle
  task automatic drain();
    pt_if.valid = 1'b0;
    while (bins_due.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_bins(logic [6:0] n);
    drain();
    cfg_if.bin_count = n;
    cfg_if.valid     = 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    bins_reg = n;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic point_t mk_point(logic wide, logic last);
    point_t p;
    int r;
    if (wide) begin
      p.x = $urandom;
      p.y = $urandom;
    end else begin
      p.x = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      p.y = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    end
    r = $urandom_range(9);
    p.w = r == 0 ? 32'h0 : r < 3 ? $urandom : $urandom_range(32'h0003_0000, 32'h0000_4000);
    p.v = $urandom_range(1) ? $urandom : $urandom_range(32'h000A_0000);
    p.last = last;
    return p;
  endfunction

  task automatic send_set(point_t s[$]);
    foreach (s[i]) begin
      s[i].last = (i == s.size() - 1);
      send_point(s[i]);
    end
  endtask

  task automatic test_corner_sets();
    point_t s[$];
    point_t p;
    // fewer than two points: every bin empty
    p = '{32'sh1234, -32'sh5678, 32'h0001_0000, 32'h0002_0000, 1'b1};
    s = '{p};
    send_set(s);
    // coordinate and weight extremes, farthest pair clamp
    s = '{'{32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0},
          '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
          '{32'sh0, 32'sh0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0}};
    send_set(s);
    // zero extent: all pairs in bin zero
    p = '{32'sh0003_0000, -32'sh0001_0000, 32'h0001_0000, 32'h0, 1'b0};
    s = '{p, p, p};
    s[1].v = 32'h0005_0000;
    s[2].v = 32'hFFFF_FFFF;
    send_set(s);
    // zero weight point saturates its rate
    s = '{'{32'sh0, 32'sh0, 32'h0, 32'h0001_0000, 1'b0},
          '{32'sh0001_0000, 32'sh0, 32'h0002_0000, 32'h0001_0000, 1'b0},
          '{32'sh0, 32'sh0004_0000, 32'h0001_8000, 32'h0, 1'b0}};
    send_set(s);
    // pair weights that floor to zero
    s = '{'{32'sh0, 32'sh0, 32'h1, 32'h0001_0000, 1'b0},
          '{32'sh0002_0000, 32'sh0, 32'h1, 32'h0, 1'b0}};
    send_set(s);
  endtask

  task automatic test_bin_counts();
    logic [6:0] sizes[4] = '{7'd0, 7'd1, 7'd64, 7'd127};
    point_t s[$];
    foreach (sizes[k]) begin
      write_bins(sizes[k]);
      s = {};
      repeat (4) s.push_back(mk_point(1'($urandom_range(1)), 1'b0));
      send_set(s);
    end
  endtask

  task automatic test_random_sets(int n_items, int gap, int stall);
    point_t s[$];
    int left;
    int sz;
    logic wide;
    write_bins(7'($urandom_range(12, 1)));
    gap_pct   = gap;
    stall_pct = stall;
    left = n_items;
    while (left > 0) begin
      sz = $urandom_range(6, 2);
      if ($urandom_range(9) == 0) sz = 1;
      wide = $urandom_range(3) == 0;
      s = {};
      repeat (sz) s.push_back(mk_point(wide, 1'b0));
      send_set(s);
      left -= sz;
    end
    drain();  // sender holds until every bin word is back
  endtask

  initial begin
    rst_n = 1'b0;
    pt_if.valid = 1'b0;
    pt_if.coord_x = '0;
    pt_if.coord_y = '0;
    pt_if.offset_weight = '0;
    pt_if.observed_value = '0;
    pt_if.last_point = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.bin_count = '0;
    res_if.ready = 1'b0;
    st_count = 0;
    bins_reg = 7'd16;
    gap_pct = 0;
    stall_pct = 0;
    errors = 0;
    n_points = 0;
    n_sets = 0;
    n_bins = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_corner_sets();
    test_bin_counts();
    test_random_sets(60, 0, 0);
    test_random_sets(60, 46, 0);
    test_random_sets(60, 0, 46);
    test_random_sets(60, 17, 17);

    drain();
    $display("covered %0d points in %0d sets, %0d bin words checked", n_points, n_sets, n_bins);
    $display("bin counts 0, 1, 64, 127 and random; idle and stall mixes applied");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/wsv_pkg.sv
design/wsv_if.sv
design/wsv_ram.sv
design/wsv_alu.sv
design/weighted_semivariogram_unit.sv
sim/tb.sv
